@@ rtl/core/button_combo_and_brightness_qualifier_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the button combo and brightness qualifier
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_COMBO_AND_BRIGHTNESS_QUALIFIER_ASSERT_SVH
`define BUTTON_COMBO_AND_BRIGHTNESS_QUALIFIER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BCBQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcbq: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define BCBQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcbq: next-cycle check failed");

`endif

@@ rtl/core/bcbq_pkg.sv @@
// ----------------------------------------------------------------------------
// bcbq_pkg
// Item types, register indexes and reset values of the qualifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcbq_pkg;

  typedef struct packed {
    logic               kind;
    logic [31:0]        now_ms;
    logic               clock_button;
    logic               alarm_button;
    logic signed [31:0] encoder_count;
  } in_item_t;

  typedef struct packed {
    logic       enter_changed;
    logic       enter_down;
    logic       escape_changed;
    logic       escape_down;
    logic       exit_request;
    logic       count_correct;
    logic [7:0] level;
    logic       apply_level;
    logic       save_level;
  } out_item_t;

  // item kinds
  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_HOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_HOLDOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX    = 2'd2;

  // register reset values
  localparam logic [15:0] EXIT_HOLD_RST    = 16'd2000;
  localparam logic [15:0] SAVE_HOLDOFF_RST = 16'd500;
  localparam logic [7:0]  LEVEL_MAX_RST    = 8'd255;

endpackage

@@ rtl/core/bcbq_if.sv @@
// ----------------------------------------------------------------------------
// bcbq_in_if / bcbq_out_if
// Valid/ready channels carrying poll items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bcbq_in_if;
  logic                valid;
  logic                ready;
  bcbq_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bcbq_out_if;
  logic                valid;
  logic                ready;
  bcbq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/button_combo_and_brightness_qualifier.sv @@
// ----------------------------------------------------------------------------
// button_combo_and_brightness_qualifier
// Qualifies button polls into key changes and an exit request, and the
// rotary count into a clamped brightness level with apply and save flags.
// ----------------------------------------------------------------------------
// Use:
//   in_ch  : poll items (kind, now_ms, button levels, encoder count).
//   out_ch : one result item per poll, in order.
//   cfg_*  : write-only registers (exit hold, save holdoff, level max);
//            write them only while no item is in flight.
// Timing:
//   An item accepted into the input register is evaluated against the
//   tracked state, and the result is registered and shown on out_ch; a
//   stall on out_ch can hold the item in between. One item per cycle is
//   taken while out_ch does not stall; the rate is set by the single
//   evaluation stage, which updates the state as it fills the result register.
// Reset (rst_n low, synchronous): both stages empty, tracked state cleared,
//   registers back to 2000 / 500 / 255.
// Stall: while out_ch is held the result and the input stage hold; in_ch
//   stays ready as long as the input stage is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_combo_and_brightness_qualifier_assert.svh"

module button_combo_and_brightness_qualifier (
  input  logic                               clk,
  input  logic                               rst_n,
  bcbq_in_if.sink                            in_ch,
  bcbq_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [bcbq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcbq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // configuration
  logic [15:0] exit_hold_r;
  logic [15:0] save_holdoff_r;
  logic [7:0]  level_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_hold_r    <= bcbq_pkg::EXIT_HOLD_RST;
      save_holdoff_r <= bcbq_pkg::SAVE_HOLDOFF_RST;
      level_max_r    <= bcbq_pkg::LEVEL_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bcbq_pkg::CFG_EXIT_HOLD:    exit_hold_r    <= cfg_wdata;
        bcbq_pkg::CFG_SAVE_HOLDOFF: save_holdoff_r <= cfg_wdata;
        bcbq_pkg::CFG_LEVEL_MAX:    level_max_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                in_v_r;
  bcbq_pkg::in_item_t  in_d_r;
  logic                out_v_r;
  bcbq_pkg::out_item_t out_d_r;
  logic                advance;

  assign advance      = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !in_v_r || advance;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_d_r <= in_ch.data;
    end
  end

  // tracked state
  logic        clock_held_r,    clock_held_nxt;
  logic        alarm_held_r,    alarm_held_nxt;
  logic [31:0] hold_start_r,    hold_start_nxt;
  logic        exit_latched_r,  exit_latched_nxt;
  logic [7:0]  applied_level_r, applied_level_nxt;
  logic [7:0]  saved_level_r,   saved_level_nxt;
  logic [31:0] last_save_r,     last_save_nxt;

  bcbq_pkg::out_item_t res;
  logic        neg;
  logic        over;
  logic [7:0]  lvl;
  logic [31:0] hold_elapsed;
  logic [31:0] save_elapsed;
  logic        hold_done;
  logic        holdoff_gone;

  always_comb begin
    neg  = in_d_r.encoder_count[31];
    over = (in_d_r.encoder_count[30:8] != 23'd0) ||
           (in_d_r.encoder_count[7:0] > level_max_r);
    if (neg) begin
      lvl = 8'd0;
    end else if (over) begin
      lvl = level_max_r;
    end else begin
      lvl = in_d_r.encoder_count[7:0];
    end

    hold_elapsed = in_d_r.now_ms - hold_start_r;
    save_elapsed = in_d_r.now_ms - last_save_r;
    hold_done    = hold_elapsed >= {16'd0, exit_hold_r};
    holdoff_gone = save_elapsed >= {16'd0, save_holdoff_r};

    clock_held_nxt    = clock_held_r;
    alarm_held_nxt    = alarm_held_r;
    hold_start_nxt    = hold_start_r;
    exit_latched_nxt  = exit_latched_r;
    applied_level_nxt = applied_level_r;
    saved_level_nxt   = saved_level_r;
    last_save_nxt     = last_save_r;

    res                = '0;
    res.level          = lvl;
    res.count_correct  = neg || (in_d_r.encoder_count != {24'd0, lvl});

    if (in_d_r.kind == bcbq_pkg::KIND_BEGIN) begin
      clock_held_nxt    = in_d_r.clock_button;
      alarm_held_nxt    = in_d_r.alarm_button;
      applied_level_nxt = lvl;
      saved_level_nxt   = lvl;
      last_save_nxt     = in_d_r.now_ms;
      hold_start_nxt    = 32'd0;
      exit_latched_nxt  = 1'b0;
      res.apply_level   = 1'b1;
    end else begin
      if (in_d_r.clock_button && in_d_r.alarm_button) begin
        // a start of zero reads as no hold running
        if (hold_start_r == 32'd0) begin
          hold_start_nxt = in_d_r.now_ms;
        end else if (!exit_latched_r && hold_done) begin
          // release both keys and raise exit once
          res.enter_changed  = clock_held_r;
          res.escape_changed = alarm_held_r;
          clock_held_nxt     = 1'b0;
          alarm_held_nxt     = 1'b0;
          exit_latched_nxt   = 1'b1;
          res.exit_request   = 1'b1;
        end
      end else begin
        hold_start_nxt     = 32'd0;
        res.enter_changed  = in_d_r.clock_button != clock_held_r;
        res.escape_changed = in_d_r.alarm_button != alarm_held_r;
        clock_held_nxt     = in_d_r.clock_button;
        alarm_held_nxt     = in_d_r.alarm_button;
      end

      if (lvl != applied_level_r) begin
        applied_level_nxt = lvl;
        res.apply_level   = 1'b1;
      end
      if ((lvl != saved_level_r) && holdoff_gone) begin
        saved_level_nxt = lvl;
        last_save_nxt   = in_d_r.now_ms;
        res.save_level  = 1'b1;
      end
    end

    res.enter_down  = clock_held_nxt;
    res.escape_down = alarm_held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r         <= 1'b0;
      clock_held_r    <= 1'b0;
      alarm_held_r    <= 1'b0;
      hold_start_r    <= 32'd0;
      exit_latched_r  <= 1'b0;
      applied_level_r <= 8'd0;
      saved_level_r   <= 8'd0;
      last_save_r     <= 32'd0;
    end else if (advance) begin
      out_v_r <= in_v_r;
      if (in_v_r) begin
        clock_held_r    <= clock_held_nxt;
        alarm_held_r    <= alarm_held_nxt;
        hold_start_r    <= hold_start_nxt;
        exit_latched_r  <= exit_latched_nxt;
        applied_level_r <= applied_level_nxt;
        saved_level_r   <= saved_level_nxt;
        last_save_r     <= last_save_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r) begin
      out_d_r <= res;
    end
  end

  // checks: the shown result agrees with the state it left behind
  `BCBQ_ASSERT_SAME(a_exit_latched, out_v_r && out_d_r.exit_request, exit_latched_r)
  `BCBQ_ASSERT_SAME(a_applied_tracks, out_v_r, applied_level_r == out_d_r.level)
  `BCBQ_ASSERT_SAME(a_saved_tracks, out_v_r && out_d_r.save_level, saved_level_r == out_d_r.level)
  `BCBQ_ASSERT_NEXT(a_stall_holds, out_v_r && !out_ch.ready, out_v_r && $stable(out_d_r))

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for button_combo_and_brightness_qualifier
// Drives poll items through the valid/ready channels with random idling on
// both sides. A scoreboard predicts the key, exit and brightness flags of
// every item and compares each result item field by field. It runs a
// directed opening, then sessions of random polls under several register
// settings, including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned LONG_HOLD_CYCLES = 64;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned PHASE_ITEMS      = 100;

  class poll_scoreboard;
    bcbq_pkg::out_item_t expected_q[$];
    int unsigned errors, polls, results;
    int unsigned exits, saves, applies, corrections, key_changes;

    logic [15:0] exit_hold;
    logic [15:0] save_holdoff;
    logic [7:0]  level_max;

    logic        clock_held, alarm_held, exit_latched;
    logic [31:0] hold_start, last_save;
    logic [7:0]  applied_level, saved_level;

    function new();
      exit_hold     = bcbq_pkg::EXIT_HOLD_RST;
      save_holdoff  = bcbq_pkg::SAVE_HOLDOFF_RST;
      level_max     = bcbq_pkg::LEVEL_MAX_RST;
      clock_held    = 1'b0;
      alarm_held    = 1'b0;
      exit_latched  = 1'b0;
      hold_start    = '0;
      last_save     = '0;
      applied_level = '0;
      saved_level   = '0;
    endfunction

    function void write_reg(logic [bcbq_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        bcbq_pkg::CFG_EXIT_HOLD:    exit_hold = val;
        bcbq_pkg::CFG_SAVE_HOLDOFF: save_holdoff = val;
        bcbq_pkg::CFG_LEVEL_MAX:    level_max = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Work out the result of one accepted poll and queue it.
    function void predict_poll(bcbq_pkg::in_item_t it);
      bcbq_pkg::out_item_t r;
      logic [31:0] raw;
      logic [31:0] elapsed;
      logic [7:0]  lvl;
      logic        neg;
      r   = '0;
      raw = it.encoder_count;
      neg = raw[31];
      if (neg) begin
        lvl = 8'd0;
      end else if (raw > {24'd0, level_max}) begin
        lvl = level_max;
      end else begin
        lvl = raw[7:0];
      end
      r.level         = lvl;
      r.count_correct = neg || (raw != {24'd0, lvl});

      if (it.kind == bcbq_pkg::KIND_BEGIN) begin
        clock_held    = it.clock_button;
        alarm_held    = it.alarm_button;
        applied_level = lvl;
        saved_level   = lvl;
        last_save     = it.now_ms;
        hold_start    = '0;
        exit_latched  = 1'b0;
        r.apply_level = 1'b1;
      end else begin
        if (it.clock_button && it.alarm_button) begin
          elapsed = it.now_ms - hold_start;
          // a start time of zero reads as no hold running
          if (hold_start == 32'd0) begin
            hold_start = it.now_ms;
          end else if (!exit_latched && elapsed >= {16'd0, exit_hold}) begin
            if (clock_held) begin
              clock_held      = 1'b0;
              r.enter_changed = 1'b1;
            end
            if (alarm_held) begin
              alarm_held       = 1'b0;
              r.escape_changed = 1'b1;
            end
            exit_latched   = 1'b1;
            r.exit_request = 1'b1;
          end
        end else begin
          hold_start = '0;
          if (it.clock_button != clock_held) begin
            clock_held      = it.clock_button;
            r.enter_changed = 1'b1;
          end
          if (it.alarm_button != alarm_held) begin
            alarm_held       = it.alarm_button;
            r.escape_changed = 1'b1;
          end
        end

        if (lvl != applied_level) begin
          applied_level = lvl;
          r.apply_level = 1'b1;
        end
        elapsed = it.now_ms - last_save;
        if (lvl != saved_level && elapsed >= {16'd0, save_holdoff}) begin
          saved_level  = lvl;
          last_save    = it.now_ms;
          r.save_level = 1'b1;
        end
      end

      r.enter_down  = clock_held;
      r.escape_down = alarm_held;
      expected_q.push_back(r);
      polls++;
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void compare_result(bcbq_pkg::out_item_t got);
      bcbq_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: result %h arrived with nothing expected", $time, got);
        return;
      end
      want = expected_q.pop_front();
      results++;
      check_field("enter_changed", want.enter_changed, got.enter_changed);
      check_field("enter_down", want.enter_down, got.enter_down);
      check_field("escape_changed", want.escape_changed, got.escape_changed);
      check_field("escape_down", want.escape_down, got.escape_down);
      check_field("exit_request", want.exit_request, got.exit_request);
      check_field("count_correct", want.count_correct, got.count_correct);
      check_field("level", want.level, got.level);
      check_field("apply_level", want.apply_level, got.apply_level);
      check_field("save_level", want.save_level, got.save_level);
      exits       += want.exit_request;
      saves       += want.save_level;
      applies     += want.apply_level;
      corrections += want.count_correct;
      key_changes += want.enter_changed + want.escape_changed;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [bcbq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bcbq_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bcbq_in_if  in_ch ();
  bcbq_out_if out_ch ();

  poll_scoreboard sb;
  bit             calm;
  bit             long_hold_req;
  int unsigned    cycle_count;

  button_combo_and_brightness_qualifier uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bcbq_pkg::in_item_t make_item(logic kind, logic [31:0] now,
                                                   logic c, logic a, logic [31:0] enc);
    bcbq_pkg::in_item_t it;
    it.kind          = kind;
    it.now_ms        = now;
    it.clock_button  = c;
    it.alarm_button  = a;
    it.encoder_count = enc;
    return it;
  endfunction

  // Offer one item, with an occasional idle burst first, and note it on accept.
  task automatic offer(input bcbq_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.predict_poll(it);
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] hold_ms, input logic [15:0] holdoff_ms,
                          input logic [7:0] lmax);
    cfg_we    <= 1'b1;
    cfg_index <= bcbq_pkg::CFG_EXIT_HOLD;
    cfg_wdata <= hold_ms;
    sb.write_reg(bcbq_pkg::CFG_EXIT_HOLD, hold_ms);
    @(posedge clk);
    cfg_index <= bcbq_pkg::CFG_SAVE_HOLDOFF;
    cfg_wdata <= holdoff_ms;
    sb.write_reg(bcbq_pkg::CFG_SAVE_HOLDOFF, holdoff_ms);
    @(posedge clk);
    cfg_index <= bcbq_pkg::CFG_LEVEL_MAX;
    cfg_wdata <= {8'd0, lmax};
    sb.write_reg(bcbq_pkg::CFG_LEVEL_MAX, {8'd0, lmax});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sessions: a begin item (mostly), then polls with rising time, sticky
  // button patterns and a drifting encoder count; some noise mixed in.
  task automatic run_sessions(input int unsigned n_items, input bit with_hold_off);
    int unsigned        sent, span, nlen;
    bit                 hold_off_done;
    logic [31:0]        now;
    logic               cb, ab;
    int                 enc;
    bcbq_pkg::in_item_t it;
    sent          = 0;
    hold_off_done = 1'b0;
    span = ((sb.exit_hold > sb.save_holdoff) ? sb.exit_hold : sb.save_holdoff) / 4 + 16;
    while (sent < n_items) begin
      case ($urandom_range(0, 3))
        0: now = $urandom;
        1: now = 32'hFFFF_FFFF - $urandom_range(0, 4 * span);
        2: now = 32'd0;
        default: now = $urandom_range(0, 100000);
      endcase
      cb  = $urandom_range(0, 1);
      ab  = $urandom_range(0, 1);
      enc = int'($urandom_range(0, sb.level_max + 8));
      if ($urandom_range(0, 7) != 0) begin
        offer(make_item(bcbq_pkg::KIND_BEGIN, now, cb, ab, enc));
        sent++;
      end
      nlen = $urandom_range(4, 30);
      repeat (nlen) begin
        if (with_hold_off && !hold_off_done && sent >= n_items / 2) begin
          long_hold_req = 1'b1;
          hold_off_done = 1'b1;
        end
        if ($urandom_range(0, 19) == 0) begin
          it = make_item($urandom_range(0, 1), $urandom, $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom);
        end else begin
          case ($urandom_range(0, 15))
            0: now = now + $urandom_range(0, 70000);
            1: now = now + $urandom;
            default: now = now + $urandom_range(0, span);
          endcase
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: begin cb = 1'b1; ab = 1'b1; end
              4, 5: begin cb = 1'b0; ab = 1'b0; end
              6: begin cb = 1'b1; ab = 1'b0; end
              7: begin cb = 1'b0; ab = 1'b1; end
              default: begin cb = $urandom_range(0, 1); ab = $urandom_range(0, 1); end
            endcase
          end
          case ($urandom_range(0, 7))
            0: enc = int'($urandom);
            1: enc = -int'($urandom_range(1, 20));
            2, 3: enc = int'($urandom_range(0, sb.level_max + 8));
            default: enc = enc + int'($urandom_range(0, 6)) - 3;
          endcase
          it = make_item(bcbq_pkg::KIND_POLL, now, cb, ab, enc);
        end
        offer(it);
        sent++;
      end
    end
  endtask

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (int i = 0; i < LONG_HOLD_CYCLES; i++) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.compare_result(out_ch.data);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    calm         = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: key edges, a full hold, hold after exit, clamping
    offer(make_item(bcbq_pkg::KIND_BEGIN, 32'd1000, 1'b0, 1'b0, 32'd100));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd1010, 1'b1, 1'b0, 32'd100));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd1020, 1'b1, 1'b1, 32'hFFFF_FFFF));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd1500, 1'b1, 1'b1, 32'h7FFF_FFFF));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd3020, 1'b1, 1'b1, 32'd255));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd4000, 1'b1, 1'b1, 32'd256));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd4001, 1'b0, 1'b1, 32'h8000_0000));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd4002, 1'b0, 1'b0, 32'd0));
    // hold started at time zero restarts on the next combined poll
    offer(make_item(bcbq_pkg::KIND_BEGIN, 32'd0, 1'b1, 1'b1, 32'd50));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd0, 1'b1, 1'b1, 32'd50));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd5000, 1'b1, 1'b1, 32'd50));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd7000, 1'b1, 1'b1, 32'd50));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd51));
    // hold across the time wrap
    offer(make_item(bcbq_pkg::KIND_BEGIN, 32'hFFFF_FF00, 1'b0, 1'b0, 32'd10));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'hFFFF_FFF0, 1'b1, 1'b1, 32'd10));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'h0000_07C0, 1'b1, 1'b1, 32'd12));
    drain();

    // zero exit hold completes on the poll after the start; zero level max
    set_regs(16'd0, 16'd0, 8'd0);
    offer(make_item(bcbq_pkg::KIND_BEGIN, 32'd5, 1'b1, 1'b1, 32'd7));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd6, 1'b1, 1'b1, 32'd7));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd6, 1'b1, 1'b1, 32'd7));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd7, 1'b0, 1'b0, 32'hFFFF_FFFB));
    drain();

    set_regs(16'hFFFF, 16'hFFFF, 8'd255);
    offer(make_item(bcbq_pkg::KIND_BEGIN, 32'd100, 1'b0, 1'b0, 32'd255));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd200, 1'b1, 1'b1, 32'd255));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd65734, 1'b1, 1'b1, 32'd255));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd65735, 1'b1, 1'b1, 32'd1));
    offer(make_item(bcbq_pkg::KIND_POLL, 32'd65736, 1'b1, 1'b0, 32'd254));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_regs(bcbq_pkg::EXIT_HOLD_RST, bcbq_pkg::SAVE_HOLDOFF_RST,
                    bcbq_pkg::LEVEL_MAX_RST);
        1: set_regs(16'd1, 16'd0, 8'd1);
        2: set_regs(16'hFFFF, 16'hFFFF, 8'd255);
        3: set_regs(16'd0, 16'hFFFF, 8'd0);
        default: set_regs($urandom_range(0, 3000), $urandom_range(0, 1500),
                          $urandom_range(0, 255));
      endcase
      // no idling on either side in the closing phase
      calm = (ph == PHASES - 1);
      run_sessions(PHASE_ITEMS, ph == 1);
      drain();
    end
    repeat (8) @(posedge clk);

    $display("covered %0d polls and %0d results in %0d cycles over %0d register settings",
             sb.polls, sb.results, cycle_count, PHASES + 3);
    $display("seen %0d exit requests, %0d saves, %0d level applies, %0d corrections, %0d key changes",
             sb.exits, sb.saves, sb.applies, sb.corrections, sb.key_changes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
